// ===== rtl/imu_dfr_pkg.sv =====
// imu_dfr_pkg: shared types and constants for the serial frame deframer
// no dependencies; used by every module of the block

package imu_dfr_pkg;

  // frame geometry
  localparam int FRAME_BYTES   = 11;
  localparam int PAYLOAD_BYTES = 8;
  localparam int WORDS         = PAYLOAD_BYTES / 2;

  // byte position codes: zero means hunting, the last one is the checksum byte
  localparam logic [3:0] POS_HUNT     = 4'd0;
  localparam logic [3:0] POS_TYPE     = 4'd1;
  localparam logic [3:0] POS_DATA0    = 4'd2;
  localparam logic [3:0] POS_CHECKSUM = 4'(FRAME_BYTES - 1);

  // configuration register indexes
  localparam logic [1:0] CFG_HEADER_BYTE = 2'd0;
  localparam logic [1:0] CFG_TYPE_BASE   = 2'd1;
  localparam logic [1:0] CFG_TYPE_COUNT  = 2'd2;

  // configuration reset values
  localparam logic [7:0] HEADER_BYTE_RST = 8'd85;
  localparam logic [7:0] TYPE_BASE_RST   = 8'd80;
  localparam logic [4:0] TYPE_COUNT_RST  = 5'd11;

  // frame status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_TYPE     = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] type_base;
    logic [4:0] type_count;
  } cfg_t;

  typedef struct packed {
    status_t            frame_status;
    logic [7:0]         type_code;
    logic [WORDS-1:0][15:0] words;
  } result_t;

endpackage

// ===== rtl/imu_dfr_if.sv =====
// imu_dfr_byte_if / imu_dfr_frame_if: valid/ready channels of the deframer
// depends on nothing but plain logic types

interface imu_dfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_last;

  modport source (output valid, output rx_byte, output chunk_last, input ready);
  modport sink   (input valid, input rx_byte, input chunk_last, output ready);
endinterface

interface imu_dfr_frame_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  type_code;
  logic [15:0] word0;
  logic [15:0] word1;
  logic [15:0] word2;
  logic [15:0] word3;

  modport source (output valid, output frame_status, output type_code,
                  output word0, output word1, output word2, output word3,
                  input ready);
  modport sink   (input valid, input frame_status, input type_code,
                  input word0, input word1, input word2, input word3,
                  output ready);
endinterface

// ===== rtl/imu_dfr_cfg.sv =====
// imu_dfr_cfg: configuration registers of the deframer
// depends on imu_dfr_pkg

module imu_dfr_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output imu_dfr_pkg::cfg_t  cfg
);

  // register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte <= imu_dfr_pkg::HEADER_BYTE_RST;
      cfg.type_base   <= imu_dfr_pkg::TYPE_BASE_RST;
      cfg.type_count  <= imu_dfr_pkg::TYPE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        imu_dfr_pkg::CFG_HEADER_BYTE: cfg.header_byte <= cfg_data;
        imu_dfr_pkg::CFG_TYPE_BASE:   cfg.type_base   <= cfg_data;
        imu_dfr_pkg::CFG_TYPE_COUNT:  cfg.type_count  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/imu_dfr_collect.sv =====
// imu_dfr_collect: header hunt, byte collection, running sum and frame check
// depends on imu_dfr_pkg

module imu_dfr_collect (
  input  logic                 clk,
  input  logic                 rst,
  input  imu_dfr_pkg::cfg_t    cfg,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  logic                 chunk_last,
  output logic                 res_valid,
  output imu_dfr_pkg::result_t res
);

  logic [3:0] byte_position, byte_position_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] type_hold, type_hold_next;
  logic [imu_dfr_pkg::PAYLOAD_BYTES-1:0][7:0] payload_bytes;
  logic       payload_we;
  logic [3:0] pos_off;
  logic [2:0] payload_idx;
  logic [7:0] type_off;
  logic       type_ok;

  assign pos_off     = byte_position - imu_dfr_pkg::POS_DATA0;
  assign payload_idx = pos_off[2:0];

  // type range check, no wrap past the top code
  assign type_off = type_hold - cfg.type_base;
  assign type_ok  = (type_hold >= cfg.type_base) && (type_off < {3'b000, cfg.type_count});

  // next state and result
  always_comb begin
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    type_hold_next     = type_hold;
    payload_we         = 1'b0;
    res_valid          = 1'b0;
    res.type_code      = type_hold;
    for (int k = 0; k < imu_dfr_pkg::WORDS; k++) begin
      res.words[k] = {payload_bytes[2*k+1], payload_bytes[2*k]};
    end
    if (running_sum != rx_byte) begin
      res.frame_status = imu_dfr_pkg::ST_CHECKSUM;
    end else if (!type_ok) begin
      res.frame_status = imu_dfr_pkg::ST_TYPE;
    end else begin
      res.frame_status = imu_dfr_pkg::ST_OK;
    end

    if (accept) begin
      if (byte_position == imu_dfr_pkg::POS_HUNT) begin
        if (rx_byte == cfg.header_byte) begin
          running_sum_next   = rx_byte;
          byte_position_next = imu_dfr_pkg::POS_TYPE;
        end
      end else if (byte_position == imu_dfr_pkg::POS_TYPE) begin
        type_hold_next     = rx_byte;
        running_sum_next   = running_sum + rx_byte;
        byte_position_next = imu_dfr_pkg::POS_DATA0;
      end else if (byte_position < imu_dfr_pkg::POS_CHECKSUM) begin
        payload_we         = 1'b1;
        running_sum_next   = running_sum + rx_byte;
        byte_position_next = byte_position + 4'd1;
      end else begin
        res_valid          = 1'b1;
        running_sum_next   = 8'd0;
        byte_position_next = imu_dfr_pkg::POS_HUNT;
      end
      // chunk end drops any partial frame
      if (chunk_last && (byte_position_next != imu_dfr_pkg::POS_HUNT)) begin
        running_sum_next   = 8'd0;
        byte_position_next = imu_dfr_pkg::POS_HUNT;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= imu_dfr_pkg::POS_HUNT;
      running_sum   <= 8'd0;
      type_hold     <= 8'd0;
    end else begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      type_hold     <= type_hold_next;
    end
  end

  // payload bytes, every frame writes all of them before the check
  always_ff @(posedge clk) begin
    if (payload_we) begin
      payload_bytes[payload_idx] <= rx_byte;
    end
  end

endmodule

// ===== rtl/imu_dfr_out_reg.sv =====
// imu_dfr_out_reg: result register between frame check and output channel
// depends on imu_dfr_pkg

module imu_dfr_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_valid,
  input  imu_dfr_pkg::result_t res,
  output logic                 take_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output imu_dfr_pkg::result_t out_res
);

  // new result may enter when the register is empty or drains this cycle
  assign take_ok = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_ok) begin
      out_valid <= res_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take_ok && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ===== rtl/imu_serial_frame_deframer.sv =====
// imu_serial_frame_deframer: fixed-length frame sync with 8-bit sum checksum
// a frame result is registered and becomes valid in the cycle after its checksum byte is taken
// throughput: one byte per cycle while the result register is free or draining
// synchronous active-high reset: hunting state, empty result register,
// configuration registers at their defaults
// depends on imu_dfr_pkg, imu_dfr_if, imu_dfr_cfg, imu_dfr_collect, imu_dfr_out_reg

module imu_serial_frame_deframer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [7:0]             cfg_data,
  imu_dfr_byte_if.sink           in_ch,
  imu_dfr_frame_if.source        out_ch
);

  imu_dfr_pkg::cfg_t    cfg;
  imu_dfr_pkg::result_t res;
  imu_dfr_pkg::result_t out_res;
  logic                 res_valid;
  logic                 take_ok;
  logic                 accept;

  // input transaction
  assign in_ch.ready = take_ok;
  assign accept      = in_ch.valid && take_ok;

  imu_dfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  imu_dfr_collect u_collect (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .rx_byte    (in_ch.rx_byte),
    .chunk_last (in_ch.chunk_last),
    .res_valid  (res_valid),
    .res        (res)
  );

  imu_dfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .take_ok   (take_ok),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // output payload
  assign out_ch.frame_status = out_res.frame_status;
  assign out_ch.type_code    = out_res.type_code;
  assign out_ch.word0        = out_res.words[0];
  assign out_ch.word1        = out_res.words[1];
  assign out_ch.word2        = out_res.words[2];
  assign out_ch.word3        = out_res.words[3];

endmodule

// ===== bench/imu_dfr_frame_checker.sv =====
// imu_dfr_frame_checker: watches the byte and frame channels of the deframer,
// predicts every frame result and compares it field by field
// depends on imu_dfr_pkg and the channel interfaces in imu_dfr_if

module imu_dfr_frame_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  imu_dfr_byte_if    byte_ch,
  imu_dfr_frame_if   frame_ch,
  output int         mismatches,
  output int         frames_due_cnt
);
  import imu_dfr_pkg::*;

  // register copies
  logic [7:0] hdr_q;
  logic [7:0] base_q;
  logic [4:0] count_q;

  // frame collection state
  logic [3:0] pos_q;
  logic [7:0] sum_q;
  logic [7:0] type_q;
  logic [7:0] payload_q [PAYLOAD_BYTES];

  result_t frames_due [$];
  int      errs = 0;

  // no wrap past 255, a zero count accepts nothing
  function automatic bit type_accepted(input logic [7:0] t);
    return (t >= base_q) && ((int'(t) - int'(base_q)) < int'(count_q));
  endfunction

  // advance the frame state by one byte, queue a result on the checksum byte
  task automatic deframe_byte(input logic [7:0] b, input logic last);
    result_t r;
    int      k;
    if (pos_q == POS_HUNT) begin
      if (b == hdr_q) begin
        sum_q = b;
        pos_q = POS_TYPE;
      end
    end else if (pos_q == POS_TYPE) begin
      type_q = b;
      sum_q  = sum_q + b;
      pos_q  = POS_DATA0;
    end else if (pos_q < POS_CHECKSUM) begin
      payload_q[pos_q - POS_DATA0] = b;
      sum_q = sum_q + b;
      pos_q = pos_q + 4'd1;
    end else begin
      // checksum test wins over the type test
      if (sum_q != b) begin
        r.frame_status = ST_CHECKSUM;
      end else if (!type_accepted(type_q)) begin
        r.frame_status = ST_TYPE;
      end else begin
        r.frame_status = ST_OK;
      end
      r.type_code = type_q;
      for (k = 0; k < WORDS; k++) begin
        r.words[k] = {payload_q[2*k+1], payload_q[2*k]};
      end
      frames_due.push_back(r);
      pos_q = POS_HUNT;
      sum_q = '0;
    end
    // chunk end drops whatever partial frame is left
    if (last && pos_q != POS_HUNT) begin
      pos_q = POS_HUNT;
      sum_q = '0;
    end
  endtask

  // compare one frame transaction with the oldest prediction
  task automatic check_frame();
    result_t want;
    if (frames_due.size() == 0) begin
      errs++;
      if (errs <= 10) begin
        $display("unexpected frame: status %0d type %02h words %04h %04h %04h %04h",
                 frame_ch.frame_status, frame_ch.type_code, frame_ch.word0,
                 frame_ch.word1, frame_ch.word2, frame_ch.word3);
      end
    end else begin
      want = frames_due.pop_front();
      if (frame_ch.frame_status !== want.frame_status ||
          frame_ch.type_code !== want.type_code ||
          frame_ch.word0 !== want.words[0] || frame_ch.word1 !== want.words[1] ||
          frame_ch.word2 !== want.words[2] || frame_ch.word3 !== want.words[3]) begin
        errs++;
        if (errs <= 10) begin
          $display("frame mismatch: expected status %0d type %02h words %04h %04h %04h %04h",
                   want.frame_status, want.type_code, want.words[0], want.words[1],
                   want.words[2], want.words[3]);
          $display("                actual   status %0d type %02h words %04h %04h %04h %04h",
                   frame_ch.frame_status, frame_ch.type_code, frame_ch.word0,
                   frame_ch.word1, frame_ch.word2, frame_ch.word3);
        end
      end
    end
  endtask

  // sample both channels and the register port at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      hdr_q   = HEADER_BYTE_RST;
      base_q  = TYPE_BASE_RST;
      count_q = TYPE_COUNT_RST;
      pos_q   = POS_HUNT;
      sum_q   = '0;
      type_q  = '0;
      frames_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEADER_BYTE: hdr_q   = cfg_data;
          CFG_TYPE_BASE:   base_q  = cfg_data;
          CFG_TYPE_COUNT:  count_q = cfg_data[4:0];
          default: ;
        endcase
      end
      if (frame_ch.valid && frame_ch.ready) begin
        check_frame();
      end
      if (byte_ch.valid && byte_ch.ready) begin
        deframe_byte(byte_ch.rx_byte, byte_ch.chunk_last);
      end
    end
    mismatches     <= errs;
    frames_due_cnt <= frames_due.size();
  end

endmodule

// ===== bench/imu_serial_frame_deframer_test.sv =====
// imu_serial_frame_deframer_test: drives bytes and register writes into the
// deframer and gives the verdict; checking is done by imu_dfr_frame_checker
// depends on imu_dfr_pkg, imu_dfr_if, the deframer RTL and the checker

module imu_serial_frame_deframer_test;
  import imu_dfr_pkg::*;

  localparam logic [1:0] CFG_SPARE  = 2'd3;  // index past the register list
  localparam int         RUN_LIMIT  = 5_000_000;
  localparam int         LONG_HOLD  = 120;
  localparam int         PHASE_BYTES = 320;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         mismatches;
  int         frames_due_cnt;

  // register values as last written, used to build frames
  logic [7:0] hdr;
  logic [7:0] tbase;
  logic [4:0] tcount;

  bit idle_allowed;
  bit src_idle_on;
  bit snk_idle_on;
  bit hold_req;
  int bytes_sent;

  imu_dfr_byte_if  in_ch ();
  imu_dfr_frame_if out_ch ();

  imu_serial_frame_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  imu_dfr_frame_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .byte_ch        (in_ch),
    .frame_ch       (out_ch),
    .mismatches     (mismatches),
    .frames_due_cnt (frames_due_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // frame receiver: random stall bursts plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one byte, optionally after an idle burst, and wait for the transaction
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (src_idle_on && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.rx_byte    <= b;
    in_ch.chunk_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // send a frame; cut is the position carrying chunk end (-1 for none),
  // bytes after the cut are not sent
  task automatic send_frame_of(input logic [7:0] typ, input logic [63:0] data,
                               input logic [7:0] sum_flip, input int cut);
    logic [7:0] fb [11];
    logic [7:0] s;
    int         k;
    fb[0] = hdr;
    fb[1] = typ;
    for (k = 0; k < PAYLOAD_BYTES; k++) fb[2+k] = data[8*k +: 8];
    s = '0;
    for (k = 0; k < FRAME_BYTES - 1; k++) s = s + fb[k];
    fb[10] = s ^ sum_flip;
    for (k = 0; k < FRAME_BYTES; k++) begin
      send_byte(fb[k], k == cut);
      if (k == cut) break;
    end
  endtask

  // random frame with type and data drawn near the interesting values
  task automatic send_frame();
    logic [7:0]  typ;
    logic [63:0] data;
    logic [7:0]  flip;
    int          cut;
    int          k;
    case ($urandom_range(0, 7))
      0:       typ = tbase - 8'd1;
      1:       typ = tbase;
      2:       typ = tbase + {3'b0, tcount} - 8'd1;
      3:       typ = tbase + {3'b0, tcount};
      4:       typ = 8'h00;
      5:       typ = 8'hff;
      6:       typ = hdr;
      default: typ = 8'($urandom);
    endcase
    for (k = 0; k < PAYLOAD_BYTES; k++) begin
      case ($urandom_range(0, 9))
        0:       data[8*k +: 8] = 8'h00;
        1:       data[8*k +: 8] = 8'hff;
        2:       data[8*k +: 8] = hdr;
        default: data[8*k +: 8] = 8'($urandom);
      endcase
    end
    flip = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    cut  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, FRAME_BYTES - 1) : -1;
    send_frame_of(typ, data, flip, cut);
  endtask

  // random frames mixed with line noise
  task automatic run_random(input int budget);
    int start;
    int k;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      if ($urandom_range(0, 15) == 0) begin
        src_idle_on = idle_allowed && ($urandom_range(0, 2) != 0);
        snk_idle_on = idle_allowed && ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 4) == 0) begin
        for (k = $urandom_range(1, 6); k > 0; k--) begin
          send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
      end else begin
        send_frame();
      end
    end
  endtask

  // close any partial frame, stop offering, wait for every result and a bit more
  task automatic settle();
    send_byte(8'($urandom), 1'b1);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (frames_due_cnt == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] h, input logic [7:0] b, input logic [7:0] c);
    set_reg(CFG_HEADER_BYTE, h);
    set_reg(CFG_TYPE_BASE, b);
    set_reg(CFG_TYPE_COUNT, c);
    cfg_we <= 1'b0;
    hdr    = h;
    tbase  = b;
    tcount = c[4:0];
  endtask

  // main sequence
  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_HEADER_BYTE;
    cfg_data         <= 8'h00;
    in_ch.valid      <= 1'b0;
    in_ch.rx_byte    <= 8'h00;
    in_ch.chunk_last <= 1'b0;
    hdr          = HEADER_BYTE_RST;
    tbase        = TYPE_BASE_RST;
    tcount       = TYPE_COUNT_RST;
    idle_allowed = 1'b1;
    src_idle_on  = 1'b1;
    snk_idle_on  = 1'b1;
    hold_req     = 1'b0;
    bytes_sent   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // good frame at the top of the type range, data at both extremes
    send_frame_of(8'h5a, 64'h80_00_ff_55_ff_00_ff_00, 8'h00, -1);
    // header alone with chunk end: frame opened and dropped at once
    send_byte(hdr, 1'b1);
    // type below range and bad checksum, chunk end on the checksum byte
    send_frame_of(8'h4f, 64'h01_23_45_67_89_ab_cd_ef, 8'h80, FRAME_BYTES - 1);

    // reset settings, with a long receiver hold-off so the block backs up
    hold_req = 1'b1;
    run_random(PHASE_BYTES);
    settle();

    // zero header, zero base, zero count: no type is accepted
    configure(8'h00, 8'h00, 8'h00);
    run_random(PHASE_BYTES);
    settle();

    // all-ones header, only type 255 accepted; a write to the spare index
    set_reg(CFG_SPARE, 8'($urandom));
    configure(8'hff, 8'hff, 8'd16);
    run_random(PHASE_BYTES);
    settle();

    // count at its 5-bit maximum, range runs past 255 without wrapping
    configure(8'($urandom), 8'd250, 8'hff);
    run_random(PHASE_BYTES);
    settle();

    configure(8'($urandom), 8'($urandom), 8'($urandom_range(0, 31)));
    run_random(PHASE_BYTES);
    settle();

    // back to defaults, full rate on both sides
    idle_allowed = 1'b0;
    src_idle_on  = 1'b0;
    snk_idle_on  = 1'b0;
    configure(HEADER_BYTE_RST, TYPE_BASE_RST, {3'b0, TYPE_COUNT_RST});
    run_random(PHASE_BYTES);
    settle();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && frames_due_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/imu_dfr_pkg.sv
rtl/imu_dfr_if.sv
rtl/imu_dfr_cfg.sv
rtl/imu_dfr_collect.sv
rtl/imu_dfr_out_reg.sv
rtl/imu_serial_frame_deframer.sv
bench/imu_dfr_frame_checker.sv
bench/imu_serial_frame_deframer_test.sv
